@@ rtl/core/wam_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, types and controller/datapath command structs for the
// window average, minimum and maximum block; no dependencies
package wam_pkg;

  localparam int WINDOW_MAX = 1024;
  localparam int AXES       = 3;
  localparam int SAMPLE_W   = 16;
  localparam int LEN_W      = 11;
  localparam int LEN_RESET  = 16;
  localparam int ADDR_W     = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W      = SAMPLE_W + CNT_W;
  localparam int DIV_STEPS  = SUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // word index of each configuration register
  localparam logic [PADDR_W-3:0] REG_WINDOW_LENGTH = '0;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [CNT_W-1:0]           count_t;

  typedef struct packed {
    sample_t x;
    sample_t y;
    sample_t z;
  } sample_set_t;

  typedef struct packed {
    logic capture;
    logic store;
    logic rd;
    logic div_init;
    logic div_step;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } status_t;

endpackage

@@ rtl/core/wam_if.sv @@
`timescale 1ns / 1ps
// valid/ready channels for sample requests and result requests
// depends on wam_pkg
interface wam_sample_if import wam_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_x;
  sample_t sample_y;
  sample_t sample_z;

  modport source (output valid, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

interface wam_result_if import wam_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t mean_x;
  sample_t mean_y;
  sample_t mean_z;
  sample_t min_x;
  sample_t max_x;
  sample_t min_y;
  sample_t max_y;
  sample_t min_z;
  sample_t max_z;

  modport source (output valid, mean_x, mean_y, mean_z, min_x, max_x, min_y, max_y,
                  min_z, max_z, input ready);
  modport sink   (input valid, mean_x, mean_y, mean_z, min_x, max_x, min_y, max_y,
                  min_z, max_z, output ready);
endinterface

@@ rtl/core/wam_regs.sv @@
`timescale 1ns / 1ps
// apb configuration register file: window_length
// depends on wam_pkg
module wam_regs import wam_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [LEN_W-1:0]   window_length
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_WINDOW_LENGTH);
  assign prdata  = reg_sel ? PDATA_W'(window_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LEN_W'(LEN_RESET);
    end else if (wr_en && reg_sel) begin
      window_length <= pwdata[LEN_W-1:0];
    end
  end

endmodule

@@ rtl/core/wam_ctrl.sv @@
`timescale 1ns / 1ps
// controller: sequences store, window scan, divide and result hand-off
// depends on wam_pkg
module wam_ctrl import wam_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output cmd_t    cmd,
  input  status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STORE,
    S_SCAN,
    S_DRAIN,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  state_t               state;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:  cmd.capture     = in_valid;
      S_STORE: cmd.store       = 1'b1;
      S_SCAN:  cmd.rd          = 1'b1;
      S_PREP:  cmd.div_init    = 1'b1;
      S_DIV:   cmd.div_step    = 1'b1;
      S_DONE:  cmd.load_result = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result may replace one taken at this same edge
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_STORE;
        end
        S_STORE: state <= S_SCAN;
        S_SCAN: begin
          if (status.scan_last) state <= S_DRAIN;
        end
        // last read data is accumulated here
        S_DRAIN: state <= S_PREP;
        S_PREP: begin
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) state <= S_DONE;
        end
        // wait here while an earlier result is still held
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/wam_datapath.sv @@
`timescale 1ns / 1ps
// datapath: window memory, scan address generator, per-axis accumulators
// and bit-serial dividers, result registers; depends on wam_pkg
module wam_datapath import wam_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output status_t          status,
  input  logic [LEN_W-1:0] window_length,
  input  sample_t          sample_x,
  input  sample_t          sample_y,
  input  sample_t          sample_z,
  output sample_t          mean_x,
  output sample_t          mean_y,
  output sample_t          mean_z,
  output sample_t          min_x,
  output sample_t          max_x,
  output sample_t          min_y,
  output sample_t          max_y,
  output sample_t          min_z,
  output sample_t          max_z
);

  sample_set_t mem [WINDOW_MAX];
  sample_set_t sample_q;
  sample_set_t rdata;

  addr_t   newest;
  addr_t   rd_ptr;
  count_t  fill;
  count_t  rd_idx;
  count_t  eff_len;
  logic    rd_vld;
  logic    rd_first;
  logic    rd_written;

  sample_t             lane_v   [AXES];
  logic signed [SUM_W-1:0] sum  [AXES];
  sample_t             mn       [AXES];
  sample_t             mx       [AXES];
  logic [SUM_W-1:0]    quo      [AXES];
  logic [CNT_W-1:0]    rem      [AXES];
  logic                neg      [AXES];
  logic [CNT_W:0]      rem_shift[AXES];
  logic [CNT_W:0]      rem_diff [AXES];
  logic                fits     [AXES];
  logic [SUM_W-1:0]    q_signed [AXES];

  // zero length acts as one, longer than the store saturates
  always_comb begin
    if (window_length == '0) begin
      eff_len = count_t'(1);
    end else if (32'(window_length) > WINDOW_MAX) begin
      eff_len = count_t'(WINDOW_MAX);
    end else begin
      eff_len = count_t'(window_length);
    end
  end

  assign status.scan_last = (rd_idx == eff_len - 1'b1);

  // ring pointers and fill count; slots beyond the fill read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      newest <= '0;
      fill   <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd;
      if (cmd.capture) begin
        newest <= (newest == addr_t'(WINDOW_MAX - 1)) ? '0 : newest + 1'b1;
        if (fill != count_t'(WINDOW_MAX)) fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_q <= '{x: sample_x, y: sample_y, z: sample_z};
    end
    if (cmd.store) begin
      mem[newest] <= sample_q;
      rd_ptr      <= newest;
      rd_idx      <= '0;
    end
    if (cmd.rd) begin
      rdata      <= mem[rd_ptr];
      rd_first   <= (rd_idx == '0);
      rd_written <= (rd_idx < fill);
      rd_ptr     <= (rd_ptr == '0) ? addr_t'(WINDOW_MAX - 1) : rd_ptr - 1'b1;
      rd_idx     <= rd_idx + 1'b1;
    end
  end

  assign lane_v[0] = rd_written ? rdata.x : '0;
  assign lane_v[1] = rd_written ? rdata.y : '0;
  assign lane_v[2] = rd_written ? rdata.z : '0;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      rem_shift[a] = {rem[a], quo[a][SUM_W-1]};
      rem_diff[a]  = rem_shift[a] - {1'b0, eff_len};
      fits[a]      = (rem_shift[a] >= {1'b0, eff_len});
      q_signed[a]  = neg[a] ? SUM_W'(-quo[a]) : quo[a];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      if (rd_vld) begin
        if (rd_first) begin
          sum[a] <= SUM_W'(lane_v[a]);
          mn[a]  <= lane_v[a];
          mx[a]  <= lane_v[a];
        end else begin
          sum[a] <= sum[a] + SUM_W'(lane_v[a]);
          if (lane_v[a] < mn[a]) mn[a] <= lane_v[a];
          if (lane_v[a] > mx[a]) mx[a] <= lane_v[a];
        end
      end
      // restoring divide on the magnitude, sign put back at the end
      if (cmd.div_init) begin
        neg[a] <= sum[a][SUM_W-1];
        quo[a] <= sum[a][SUM_W-1] ? SUM_W'(-sum[a]) : SUM_W'(sum[a]);
        rem[a] <= '0;
      end else if (cmd.div_step) begin
        quo[a] <= {quo[a][SUM_W-2:0], fits[a]};
        rem[a] <= fits[a] ? rem_diff[a][CNT_W-1:0] : rem_shift[a][CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      mean_x <= q_signed[0][SAMPLE_W-1:0];
      mean_y <= q_signed[1][SAMPLE_W-1:0];
      mean_z <= q_signed[2][SAMPLE_W-1:0];
      min_x  <= mn[0];
      max_x  <= mx[0];
      min_y  <= mn[1];
      max_y  <= mx[1];
      min_z  <= mn[2];
      max_z  <= mx[2];
    end
  end

endmodule

@@ rtl/core/window_average_min_max.sv @@
`timescale 1ns / 1ps
// Sliding-window mean, minimum and maximum of a three-axis sample stream.
// samples (sink): one request carries sample_x/y/z, signed Q3.12. Each
//   request writes the sample set into a 1024-entry ring and produces one
//   result request on results (source): per-axis mean (truncated toward
//   zero), minimum and maximum of the newest L samples, where L is
//   window_length clamped to 1..1024.
// Configuration: APB port, window_length at byte address 0, reset 16.
//   Write it only while no request is in flight.
// Timing: the window memory has one read port, so the scan reads the L slots
//   one after another; the divide is bit-serial, one bit per cycle. A result is
//   valid in the same cycle that samples.ready rises again, so the block works
//   on one sample at a time.
// Reset: ready right away; slots not yet written read as zero through a
//   fill count, with no clearing pass.
// Stall: the result register holds its request until results.ready. The
//   block still accepts the next sample and works on it, then waits with
//   that result until the register is free.
// depends on wam_pkg, wam_if, wam_regs, wam_ctrl, wam_datapath
module window_average_min_max import wam_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  wam_sample_if.sink         samples,
  wam_result_if.source       results
);

  logic [LEN_W-1:0] window_length;
  cmd_t             cmd;
  status_t          status;

  wam_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .window_length (window_length)
  );

  wam_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .status    (status)
  );

  wam_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .window_length (window_length),
    .sample_x      (samples.sample_x),
    .sample_y      (samples.sample_y),
    .sample_z      (samples.sample_z),
    .mean_x        (results.mean_x),
    .mean_y        (results.mean_y),
    .mean_z        (results.mean_z),
    .min_x         (results.min_x),
    .max_x         (results.max_x),
    .min_y         (results.min_y),
    .max_y         (results.max_y),
    .min_z         (results.min_z),
    .max_z         (results.max_z)
  );

endmodule

@@ rtl/core/wam_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for window_average_min_max, attached by bind
// depends on wam_pkg and window_average_min_max
module wam_checker import wam_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [9*SAMPLE_W-1:0] out_data
);

  // result request held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // one item at a time: busy right after an accepted sample
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while previous one in progress");

  // no clearing pass: ready and no result straight out of reset
  a_reset_state: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("wrong state after reset");

endmodule

bind window_average_min_max wam_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  ({results.mean_x, results.mean_y, results.mean_z,
               results.min_x, results.max_x, results.min_y,
               results.max_y, results.min_z, results.max_z})
);

@@ verif/tb_window_average_min_max.sv @@
`timescale 1ns / 1ps
// self-checking bench for window_average_min_max: bursty sample requests, a stalling
// result sink, window_length phases over the apb port and an in-bench window predictor
// depends on wam_pkg, wam_if and the window_average_min_max rtl
module tb_window_average_min_max;
  import wam_pkg::*;

  localparam int QUIET_LIMIT = 8 * (WINDOW_MAX + 64);

  typedef struct packed {
    sample_t mean_x;
    sample_t mean_y;
    sample_t mean_z;
    sample_t min_x;
    sample_t max_x;
    sample_t min_y;
    sample_t max_y;
    sample_t min_z;
    sample_t max_z;
  } window_stats_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_SHORT, STALL_LONG} stall_mode_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  wam_sample_if sample_bus ();
  wam_result_if result_bus ();

  window_average_min_max i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .samples (sample_bus),
    .results (result_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sample_set_t       pending_samples[$];
  window_stats_t     expected_stats[$];
  int                failures = 0;

  // predictor copy of the block state
  sample_t           ring[AXES][WINDOW_MAX];
  int unsigned       newest;
  logic [LEN_W-1:0]  window_len;

  function automatic window_stats_t predict_window(input sample_set_t set);
    sample_t       fresh[AXES];
    sample_t       lo[AXES];
    sample_t       hi[AXES];
    sample_t       mean[AXES];
    longint        sum;
    int unsigned   span;
    int unsigned   slot;
    window_stats_t stats;
    fresh[0] = set.x;
    fresh[1] = set.y;
    fresh[2] = set.z;
    if (window_len == 0) span = 1;
    else if (window_len > WINDOW_MAX) span = WINDOW_MAX;
    else span = window_len;
    newest = (newest + 1) % WINDOW_MAX;
    for (int a = 0; a < AXES; a++) ring[a][newest] = fresh[a];
    for (int a = 0; a < AXES; a++) begin
      sum   = 0;
      lo[a] = ring[a][newest];
      hi[a] = lo[a];
      slot  = newest;
      for (int i = 0; i < span; i++) begin
        sum += ring[a][slot];
        if (ring[a][slot] < lo[a]) lo[a] = ring[a][slot];
        if (ring[a][slot] > hi[a]) hi[a] = ring[a][slot];
        slot = (slot == 0) ? WINDOW_MAX - 1 : slot - 1;
      end
      // signed division truncates toward zero
      mean[a] = sample_t'(sum / longint'(span));
    end
    stats.mean_x = mean[0];
    stats.mean_y = mean[1];
    stats.mean_z = mean[2];
    stats.min_x  = lo[0];
    stats.max_x  = hi[0];
    stats.min_y  = lo[1];
    stats.max_y  = hi[1];
    stats.min_z  = lo[2];
    stats.max_z  = hi[2];
    return stats;
  endfunction

  function automatic void check_field(input string field, input sample_t want,
                                      input sample_t got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      failures++;
    end
  endfunction

  function automatic sample_t random_axis();
    case ($urandom_range(0, 9))
      0:       return sample_t'(16'h8000);
      1:       return sample_t'(16'h7FFF);
      2, 3:    return sample_t'($urandom_range(0, 16) - 8);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic void queue_sample(input sample_t x, input sample_t y, input sample_t z);
    sample_set_t set;
    set.x = x;
    set.y = y;
    set.z = z;
    pending_samples.push_back(set);
  endfunction

  // sample sender: bursts of random length separated by random gaps
  always @(posedge clk) begin : drive_samples
    sample_set_t next_set;
    int unsigned burst_left;
    int unsigned gap_left;
    if (rst) begin
      sample_bus.valid <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (sample_bus.valid && sample_bus.ready)
        expected_stats.push_back(predict_window({sample_bus.sample_x, sample_bus.sample_y,
                                                 sample_bus.sample_z}));
      if (!sample_bus.valid || sample_bus.ready) begin
        if (gap_left != 0 || pending_samples.size() == 0) begin
          if (gap_left != 0) gap_left--;
          sample_bus.valid    <= 1'b0;
          sample_bus.sample_x <= sample_t'($urandom());
          sample_bus.sample_y <= sample_t'($urandom());
          sample_bus.sample_z <= sample_t'($urandom());
        end else begin
          next_set = pending_samples.pop_front();
          sample_bus.valid    <= 1'b1;
          sample_bus.sample_x <= next_set.x;
          sample_bus.sample_y <= next_set.y;
          sample_bus.sample_z <= next_set.z;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // result sink: stall pattern switches between none, short and long stalls
  always @(posedge clk) begin : drive_ready
    stall_mode_t stall_mode;
    int unsigned mode_left;
    int unsigned stall_left;
    if (rst) begin
      result_bus.ready <= 1'b0;
      stall_mode = STALL_NONE;
      mode_left  = 0;
      stall_left = 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        mode_left  = $urandom_range(100, 400);
      end else begin
        mode_left--;
      end
      if (stall_left != 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        case (stall_mode)
          STALL_SHORT: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 4);
          STALL_LONG:  if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(20, 80);
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    window_stats_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (expected_stats.size() == 0) begin
        $error("result request with no sample outstanding");
        failures++;
      end else begin
        want = expected_stats.pop_front();
        check_field("mean_x", want.mean_x, result_bus.mean_x);
        check_field("mean_y", want.mean_y, result_bus.mean_y);
        check_field("mean_z", want.mean_z, result_bus.mean_z);
        check_field("min_x", want.min_x, result_bus.min_x);
        check_field("max_x", want.max_x, result_bus.max_x);
        check_field("min_y", want.min_y, result_bus.min_y);
        check_field("max_y", want.max_y, result_bus.max_y);
        check_field("min_z", want.min_z, result_bus.min_z);
        check_field("max_z", want.max_z, result_bus.max_z);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int unsigned quiet_cycles;
    if (rst || (sample_bus.valid && sample_bus.ready) ||
        (result_bus.valid && result_bus.ready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  task automatic apb_transfer(input logic write, input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {REG_WINDOW_LENGTH, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_window_length();
    logic [PDATA_W-1:0] rdata;
    apb_transfer(1'b0, '0, rdata);
    if (rdata[LEN_W-1:0] !== window_len) begin
      $error("window_length: expected %0d, actual %0d", window_len, rdata[LEN_W-1:0]);
      failures++;
    end
  endtask

  task automatic set_window_length(input logic [LEN_W-1:0] len);
    logic [PDATA_W-1:0] wdata;
    logic [PDATA_W-1:0] rdata;
    // upper data bits are noise the register must drop
    wdata = $urandom();
    wdata[LEN_W-1:0] = len;
    apb_transfer(1'b1, wdata, rdata);
    window_len = len;
    check_window_length();
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_samples.size() != 0 || sample_bus.valid || expected_stats.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] len, input int unsigned count);
    set_window_length(len);
    @(negedge clk);
    repeat (count) queue_sample(random_axis(), random_axis(), random_axis());
    wait_idle();
  endtask

  initial begin : run_test
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    sample_bus.valid    = 1'b0;
    sample_bus.sample_x = '0;
    sample_bus.sample_y = '0;
    sample_bus.sample_z = '0;
    result_bus.ready    = 1'b0;
    newest              = 0;
    window_len          = LEN_RESET;
    for (int a = 0; a < AXES; a++)
      for (int i = 0; i < WINDOW_MAX; i++) ring[a][i] = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    check_window_length();

    // reset length, unwritten slots still zero; small negative sums truncate toward zero
    @(negedge clk);
    queue_sample(16'sd0, 16'sd0, 16'sd0);
    queue_sample(-16'sd1, 16'sd1, 16'sd0);
    queue_sample(-16'sd17, 16'sd17, sample_t'(16'h8000));
    queue_sample(sample_t'(16'h7FFF), sample_t'(16'h8000), sample_t'(16'h7FFF));
    repeat (3) queue_sample(sample_t'(16'h7FFF), sample_t'(16'h7FFF), sample_t'(16'h7FFF));
    repeat (3) queue_sample(sample_t'(16'h8000), sample_t'(16'h8000), sample_t'(16'h8000));
    queue_sample(sample_t'(16'h5555), sample_t'(16'hAAAA), sample_t'(16'h00FF));
    queue_sample(sample_t'(16'hAAAA), sample_t'(16'h5555), sample_t'(16'hFF00));
    for (int i = 0; i < 10; i++)
      queue_sample(sample_t'(16'h8000), sample_t'(16'h7FFF),
                   (i % 2) ? sample_t'(16'h8000) : sample_t'(16'h7FFF));
    wait_idle();

    // zero length acts as one, lengths past the store saturate, history is kept
    run_phase(11'd0, 40);
    run_phase(11'd1, 40);
    run_phase(11'd2047, 8);
    run_phase(11'd3, 50);
    run_phase(11'd1024, 8);
    run_phase(11'd2, 40);
    run_phase(11'd7, 50);
    run_phase(11'd1025, 6);
    run_phase(11'd1023, 8);
    run_phase(11'd5, 40);
    repeat (4) run_phase(LEN_W'($urandom_range(1, 40)), 50);
    run_phase(11'd16, 50);

    repeat (64) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
